// ===== design/nufa_pkg.sv =====
package nufa_pkg;

	localparam int LEN_W = 16;
	localparam int SEQ_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	localparam logic [LEN_W-1:0] LIMIT_RST = LEN_W'(1400);
	localparam logic [LEN_W-1:0] FRAG_SIZE_RST = LEN_W'(1398);

	localparam logic [7:0] NRI_MASK = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [7:0] FU_START_BIT = 8'h80;
	localparam logic [7:0] FU_END_BIT = 8'h40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT = 2'd0,
		CFG_FRAG_SIZE = 2'd1,
		CFG_START_SEQ = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		JOB_SINGLE = 2'd0,
		JOB_FRAG_OPEN = 2'd1,
		JOB_FRAG_DATA = 2'd2
	} job_kind_t;

	typedef enum logic [1:0] {
		STEP_IND = 2'd0,
		STEP_HDR = 2'd1,
		STEP_DATA = 2'd2
	} step_t;

	typedef struct packed {
		job_kind_t kind;
		logic [7:0] data_byte;
		logic [7:0] fu_ind;
		logic [7:0] fu_hdr;
		logic first;
		logic last;
		logic [SEQ_W-1:0] seq;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/nufa_front.sv =====
module nufa_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [nufa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nufa_pkg::CFG_W-1:0] cfg_data,
	input  logic accept,
	input  logic [7:0] data_byte,
	input  logic [nufa_pkg::LEN_W-1:0] nal_length,
	output logic push,
	output nufa_pkg::job_t job
);
	import nufa_pkg::*;

	logic [LEN_W-1:0] limit_q;
	logic [LEN_W-1:0] frag_size_q;
	logic [LEN_W-1:0] pos_q;
	logic [7:0] hdr_q;
	logic [LEN_W-1:0] fill_q;
	logic frag_q;
	logic [SEQ_W-1:0] seq_q;

	logic [LEN_W-1:0] len_w;
	logic [LEN_W-1:0] psize;
	logic [LEN_W:0] pos_inc;
	logic [LEN_W:0] fill_inc;
	logic [LEN_W-1:0] rem;
	logic nal_end;
	logic first_byte;
	logic frag_new;
	logic frag_eff;
	logic plast;
	logic fu_end;
	logic pkt_done;

	always_comb begin
		len_w = (nal_length == '0) ? LEN_W'(1) : nal_length;
		psize = (frag_size_q == '0) ? LEN_W'(1) : frag_size_q;
		pos_inc = {1'b0, pos_q} + (LEN_W+1)'(1);
		fill_inc = {1'b0, fill_q} + (LEN_W+1)'(1);
		nal_end = pos_inc >= {1'b0, len_w};
		first_byte = pos_q == '0;
		frag_new = (len_w > limit_q) && ((len_w - LEN_W'(1)) > psize);
		frag_eff = first_byte ? frag_new : frag_q;
		plast = nal_end || (fill_inc >= {1'b0, psize});
		rem = (pos_q < len_w) ? (len_w - pos_q) : LEN_W'(1);
		fu_end = rem <= psize;
	end

	always_comb begin
		job.data_byte = data_byte;
		job.fu_ind = (hdr_q & NRI_MASK) | FU_A_TYPE;
		job.fu_hdr = (hdr_q & TYPE_MASK) | ((pos_q == LEN_W'(1)) ? FU_START_BIT : 8'h00)
			| (fu_end ? FU_END_BIT : 8'h00);
		job.seq = seq_q;
		if (!frag_eff) begin
			job.kind = JOB_SINGLE;
			job.first = first_byte;
			job.last = nal_end;
		end else begin
			job.kind = (fill_q == '0) ? JOB_FRAG_OPEN : JOB_FRAG_DATA;
			job.first = 1'b0;
			job.last = plast;
		end
		push = accept && !(frag_eff && first_byte);
		pkt_done = push && job.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			frag_size_q <= FRAG_SIZE_RST;
			pos_q <= '0;
			hdr_q <= '0;
			fill_q <= '0;
			frag_q <= 1'b0;
			seq_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LIMIT: limit_q <= cfg_data;
					CFG_FRAG_SIZE: frag_size_q <= cfg_data;
					CFG_START_SEQ: seq_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				pos_q <= nal_end ? '0 : pos_inc[LEN_W-1:0];
				if (first_byte) begin
					hdr_q <= data_byte;
					frag_q <= frag_new;
					fill_q <= '0;
				end else if (frag_q) begin
					fill_q <= plast ? '0 : fill_inc[LEN_W-1:0];
				end
				if (pkt_done) begin
					seq_q <= seq_q + SEQ_W'(1);
				end
			end
		end
	end

endmodule

// ===== design/nufa_fifo.sv =====
module nufa_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  nufa_pkg::job_t wr_job,
	input  logic pop,
	output nufa_pkg::job_t rd_job,
	output nufa_pkg::q_stat_t stat
);
	import nufa_pkg::*;

	job_t mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		stat.full = cnt_q == Q_CNT_W'(Q_DEPTH);
		stat.empty = cnt_q == '0;
		do_push = push && !stat.full;
		do_pop = pop && !stat.empty;
		rd_job = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue read while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== design/nufa_back.sv =====
module nufa_back (
	input  logic clk,
	input  logic arst_n,
	input  nufa_pkg::job_t head,
	input  nufa_pkg::q_stat_t stat,
	output logic pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,
	output logic m_tlast,
	output logic [1:0] m_tuser
);
	import nufa_pkg::*;

	step_t step_q;
	logic out_valid_q;
	logic [7:0] byte_q;
	logic [SEQ_W-1:0] seq_q;
	logic first_q;
	logic last_q;
	logic run_last_q;

	logic advance;
	logic job_done;
	logic [7:0] nx_byte;
	logic nx_first;
	logic nx_last;
	logic nx_run_last;
	step_t nx_step;

	always_comb begin
		advance = !stat.empty && (!out_valid_q || m_tready);
		nx_byte = head.data_byte;
		nx_first = head.first;
		nx_last = head.last;
		nx_run_last = 1'b1;
		job_done = 1'b1;
		nx_step = STEP_IND;
		if (head.kind == JOB_FRAG_OPEN) begin
			unique case (step_q)
				STEP_IND: begin
					nx_byte = head.fu_ind;
					nx_first = 1'b1;
					nx_last = 1'b0;
					nx_run_last = 1'b0;
					job_done = 1'b0;
					nx_step = STEP_HDR;
				end
				STEP_HDR: begin
					nx_byte = head.fu_hdr;
					nx_first = 1'b0;
					nx_last = 1'b0;
					nx_run_last = 1'b0;
					job_done = 1'b0;
					nx_step = STEP_DATA;
				end
				default: ;
			endcase
		end
		pop = advance && job_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IND;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q <= nx_step;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= nx_byte;
			seq_q <= head.seq;
			first_q <= nx_first;
			last_q <= nx_last;
			run_last_q <= nx_run_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {seq_q, byte_q};
	assign m_tlast = last_q;
	assign m_tuser = {run_last_q, first_q};

`ifndef SYNTHESIS
	a_step_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_IND) |-> (!stat.empty && head.kind == JOB_FRAG_OPEN))
		else $error("fragment opening step without an opening job");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(step_q))
		else $error("step advanced while output stalled");
`endif

endmodule

// ===== design/nal_unit_fu_a_packetizer_unit.sv =====
// channel | direction | tdata (low bit up)                 | tlast       | tuser (low bit up)
// s_*     | in        | data_byte[7:0], nal_length[23:8]   | -           | -
// m_*     | out       | out_byte[7:0], sequence_number[23:8] | packet_last | packet_first, run_last
// cfg_*   | in        | write: cfg_index selects, cfg_data 16 bits, no read-back
//
// One NAL byte is taken per cycle while the four-entry job queue has room.
// The output side gives one byte per cycle while m_tready is high and a job waits; a byte that
// opens an FU-A fragment gives three (indicator, FU header, data), a split NAL's header none, others one.
// Reset clears the byte position, mode, fill, sequence and the queue.
// Input and output stall independently; the queue takes up the difference.
module nal_unit_fu_a_packetizer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [nufa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nufa_pkg::CFG_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,   // data_byte, nal_length
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,   // out_byte, sequence_number
	output logic m_tlast,
	output logic [1:0] m_tuser     // packet_first, run_last
);
	import nufa_pkg::*;

	logic accept;
	logic push;
	logic pop;
	job_t wr_job;
	job_t head;
	q_stat_t stat;

	assign s_tready = !stat.full;
	assign accept = s_tvalid && s_tready;

	nufa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.data_byte(s_tdata[7:0]),
		.nal_length(s_tdata[23:8]),
		.push(push),
		.job(wr_job)
	);

	nufa_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.rd_job(head),
		.stat(stat)
	);

	nufa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.stat(stat),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule
